// File: rtl/core/vdpcpu_pkg.sv
package vdpcpu_pkg;

   localparam int VRAM_DEPTH_DEF = 16384;
   localparam int PTR_W = 14;

   typedef enum logic [1:0] {
      CMD_STATUS_READ  = 2'd0,
      CMD_DATA_READ    = 2'd1,
      CMD_DATA_WRITE   = 2'd2,
      CMD_CONTROL      = 2'd3
   } vdp_cmd_type;

   typedef enum logic [2:0] {
      REG_MODE0        = 3'd0,
      REG_MODE1        = 3'd1,
      REG_NAME_BASE    = 3'd2,
      REG_COLOR_BASE   = 3'd3,
      REG_PATTERN_BASE = 3'd4,
      REG_SPRITE_ATTR  = 3'd5,
      REG_SPRITE_PAT   = 3'd6,
      REG_TEXT_COLOR   = 3'd7
   } vdp_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_RESP
   } vdp_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic fill;
   } vdp_ctl_type;

   typedef struct packed {
      logic read_issue;
   } vdp_sts_type;

endpackage

// File: rtl/core/vdpcpu_ctrl.sv
module vdpcpu_ctrl import vdpcpu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  vdp_sts_type sts,
   output vdp_ctl_type ctl,
   output logic        busy,
   output logic        rsp_valid
);

   vdp_state_type state_ff;
   vdp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctl         = '0;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = sts.read_issue ? ST_FILL : ST_RESP;
         end
         ST_FILL: begin
            ctl.fill = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/vdpcpu_datapath.sv
module vdpcpu_datapath import vdpcpu_pkg::*; #(
   parameter int VRAM_DEPTH = VRAM_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  vdp_ctl_type      ctl,
   output vdp_sts_type      sts,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_wdata,
   input  logic [4:0]       req_fifth_sprite_index,
   input  logic             req_sprite_collision_flag,
   input  logic             req_sprite_overflow_flag,
   input  logic             req_raise_irq,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_out,
   output logic [PTR_W-1:0] rsp_vram_pointer
);

   localparam int ADDR_W = $clog2(VRAM_DEPTH);
   localparam logic [PTR_W:0] DEPTH_V = (PTR_W + 1)'(VRAM_DEPTH);

   logic [7:0] mem [VRAM_DEPTH];

   vdp_cmd_type cmd_ff, cmd_in;
   logic [7:0]  wdata_ff, wdata_in;
   logic [4:0]  fifth_ff, fifth_in;
   logic        coll_ff, coll_in;
   logic        ovf_ff, ovf_in;
   logic        raise_ff, raise_in;

   logic [15:0] cw_ff, cw_in;
   logic        pend_ff, pend_in;
   logic [7:0]  ra_ff, ra_in;
   logic        irq_ff, irq_in;
   logic [7:0]  rd_ff, rd_in;
   logic [2:0]  mode_ff, mode_in;
   logic [5:0]  flags_ff, flags_in;
   logic [3:0]  name_base_ff, name_base_in;
   logic [7:0]  color_base_ff, color_base_in;
   logic [2:0]  pat_base_ff, pat_base_in;
   logic [6:0]  sat_base_ff, sat_base_in;
   logic [2:0]  spg_base_ff, spg_base_in;
   logic [7:0]  text_ff, text_in;

   logic [7:0]       mem_q_ff;
   logic             mem_rd;
   logic             mem_wr;
   logic [PTR_W-1:0] mem_ptr;
   logic [ADDR_W-1:0] mem_idx;
   logic [15:0]      cw_new;
   logic             irq_tmp;

   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [PTR_W-1:0] a);
      logic [PTR_W:0] v;
      v = {1'b0, a};
      for (int i = 0; i < 4; i++) begin
         if (v >= DEPTH_V) begin
            v = v - DEPTH_V;
         end
      end
      return v[ADDR_W-1:0];
   endfunction

   always_comb begin
      cmd_in        = cmd_ff;
      wdata_in      = wdata_ff;
      fifth_in      = fifth_ff;
      coll_in       = coll_ff;
      ovf_in        = ovf_ff;
      raise_in      = raise_ff;
      cw_in         = cw_ff;
      pend_in       = pend_ff;
      ra_in         = ra_ff;
      irq_in        = irq_ff;
      rd_in         = rd_ff;
      mode_in       = mode_ff;
      flags_in      = flags_ff;
      name_base_in  = name_base_ff;
      color_base_in = color_base_ff;
      pat_base_in   = pat_base_ff;
      sat_base_in   = sat_base_ff;
      spg_base_in   = spg_base_ff;
      text_in       = text_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      mem_ptr       = cw_ff[PTR_W-1:0];
      cw_new        = {wdata_ff, cw_ff[7:0]};
      irq_tmp       = irq_ff | raise_ff;

      if (ctl.capture) begin
         cmd_in   = vdp_cmd_type'(req_cmd);
         wdata_in = req_wdata;
         fifth_in = req_fifth_sprite_index;
         coll_in  = req_sprite_collision_flag;
         ovf_in   = req_sprite_overflow_flag;
         raise_in = req_raise_irq;
      end

      if (ctl.execute) begin
         irq_in = irq_tmp;
         rd_in  = 8'd0;
         case (cmd_ff)
            CMD_STATUS_READ: begin
               pend_in = 1'b0;
               rd_in   = {irq_tmp, ovf_ff, coll_ff, fifth_ff};
               irq_in  = 1'b0;
            end
            CMD_DATA_READ: begin
               pend_in = 1'b0;
               rd_in   = ra_ff;
               mem_rd  = 1'b1;
               cw_in   = {cw_ff[15:14], cw_ff[PTR_W-1:0] + PTR_W'(1)};
            end
            CMD_DATA_WRITE: begin
               pend_in = 1'b0;
               mem_wr  = 1'b1;
               cw_in   = {cw_ff[15:14], cw_ff[PTR_W-1:0] + PTR_W'(1)};
            end
            CMD_CONTROL: begin
               if (!pend_ff) begin
                  cw_in   = {cw_ff[15:8], wdata_ff};
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  cw_in   = cw_new;
                  if (cw_new[15]) begin
                     case (vdp_reg_type'(cw_new[10:8]))
                        REG_MODE0: begin
                           flags_in = {flags_ff[5:1], cw_new[0]};
                           mode_in  = {cw_new[1], mode_ff[1:0]};
                        end
                        REG_MODE1: begin
                           flags_in = {cw_new[7], cw_new[6], cw_new[5],
                                       cw_new[1], cw_new[0], flags_ff[0]};
                           mode_in  = {mode_ff[2], cw_new[3], cw_new[4]};
                        end
                        REG_NAME_BASE:    name_base_in  = cw_new[3:0];
                        REG_COLOR_BASE:   color_base_in = cw_new[7:0];
                        REG_PATTERN_BASE: pat_base_in   = cw_new[2:0];
                        REG_SPRITE_ATTR:  sat_base_in   = cw_new[6:0];
                        REG_SPRITE_PAT:   spg_base_in   = cw_new[2:0];
                        REG_TEXT_COLOR:   text_in       = cw_new[7:0];
                        default:          text_in       = text_ff;
                     endcase
                  end else if (!cw_new[14]) begin
                     mem_ptr = cw_new[PTR_W-1:0];
                     mem_rd  = 1'b1;
                     cw_in   = {cw_new[15:14], cw_new[PTR_W-1:0] + PTR_W'(1)};
                  end
               end
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end

      if (ctl.fill) begin
         ra_in = mem_q_ff;
      end
   end

   assign mem_idx        = wrap_addr(mem_ptr);
   assign sts.read_issue = mem_rd;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_idx] <= wdata_ff;
      end
      if (mem_rd) begin
         mem_q_ff <= mem[mem_idx];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      wdata_ff <= wdata_in;
      fifth_ff <= fifth_in;
      coll_ff  <= coll_in;
      ovf_ff   <= ovf_in;
      raise_ff <= raise_in;
      rd_ff    <= rd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff         <= '0;
         pend_ff       <= 1'b0;
         ra_ff         <= '0;
         irq_ff        <= 1'b0;
         mode_ff       <= '0;
         flags_ff      <= '0;
         name_base_ff  <= '0;
         color_base_ff <= '0;
         pat_base_ff   <= '0;
         sat_base_ff   <= '0;
         spg_base_ff   <= '0;
         text_ff       <= '0;
      end else begin
         cw_ff         <= cw_in;
         pend_ff       <= pend_in;
         ra_ff         <= ra_in;
         irq_ff        <= irq_in;
         mode_ff       <= mode_in;
         flags_ff      <= flags_in;
         name_base_ff  <= name_base_in;
         color_base_ff <= color_base_in;
         pat_base_ff   <= pat_base_in;
         sat_base_ff   <= sat_base_in;
         spg_base_ff   <= spg_base_in;
         text_ff       <= text_in;
      end
   end

   assign rsp_read_data    = rd_ff;
   assign rsp_irq_out      = irq_ff;
   assign rsp_vram_pointer = cw_ff[PTR_W-1:0];

endmodule

// File: rtl/core/vdp_cpu_port_interface_unit.sv
// CPU port of a video display processor. A transaction is taken at a clock edge with start
// high and busy low; its result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, and the receiver cannot stall it, so it must take every strobe. Status reads,
// data writes and control writes pass through the execute and response states before the
// next accept; data reads and address loads with read-ahead also pass through a fill state,
// the registered read of the single-port video memory. No clearing pass follows reset.
module vdp_cpu_port_interface_unit import vdpcpu_pkg::*; #(
   parameter int VRAM_DEPTH = VRAM_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_wdata,
   input  logic [4:0]       req_fifth_sprite_index,
   input  logic             req_sprite_collision_flag,
   input  logic             req_sprite_overflow_flag,
   input  logic             req_raise_irq,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_out,
   output logic [PTR_W-1:0] rsp_vram_pointer
);

   vdp_ctl_type ctl;
   vdp_sts_type sts;

   vdpcpu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vdpcpu_datapath #(
      .VRAM_DEPTH (VRAM_DEPTH)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .ctl                       (ctl),
      .sts                       (sts),
      .req_cmd                   (req_cmd),
      .req_wdata                 (req_wdata),
      .req_fifth_sprite_index    (req_fifth_sprite_index),
      .req_sprite_collision_flag (req_sprite_collision_flag),
      .req_sprite_overflow_flag  (req_sprite_overflow_flag),
      .req_raise_irq             (req_raise_irq),
      .rsp_read_data             (rsp_read_data),
      .rsp_irq_out               (rsp_irq_out),
      .rsp_vram_pointer          (rsp_vram_pointer)
   );

endmodule

// File: dv/tb_vdp_cpu_port_interface_unit.sv
`timescale 1ns / 1ps

module tb_vdp_cpu_port_interface_unit;
   import vdpcpu_pkg::*;

   localparam int VRAM_SIZE = VRAM_DEPTH_DEF;
   localparam int DIR_ROWS = 24;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      vdp_cmd_type cmd;
      logic [7:0]  wdata;
      logic [4:0]  fifth_idx;
      logic        collision;
      logic        overflow;
      logic        raise_irq;
   } access_type;

   typedef struct {
      logic [7:0]       read_data;
      logic             irq;
      logic [PTR_W-1:0] ptr;
   } reply_type;

   typedef struct {
      access_type acc;
      logic       chk;
      reply_type  typed;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_cmd;
   logic [7:0]       req_wdata;
   logic [4:0]       req_fifth_sprite_index;
   logic             req_sprite_collision_flag;
   logic             req_sprite_overflow_flag;
   logic             req_raise_irq;
   logic             rsp_valid;
   logic [7:0]       rsp_read_data;
   logic             rsp_irq_out;
   logic [PTR_W-1:0] rsp_vram_pointer;

   vdp_cpu_port_interface_unit #(
      .VRAM_DEPTH(VRAM_SIZE)
   ) i_dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_cmd                   (req_cmd),
      .req_wdata                 (req_wdata),
      .req_fifth_sprite_index    (req_fifth_sprite_index),
      .req_sprite_collision_flag (req_sprite_collision_flag),
      .req_sprite_overflow_flag  (req_sprite_overflow_flag),
      .req_raise_irq             (req_raise_irq),
      .rsp_valid                 (rsp_valid),
      .rsp_read_data             (rsp_read_data),
      .rsp_irq_out               (rsp_irq_out),
      .rsp_vram_pointer          (rsp_vram_pointer)
   );

   // port state mirror
   logic [7:0]  vram_mirror [VRAM_SIZE];
   bit          vram_written [VRAM_SIZE];
   int          written_addrs [$];
   logic [15:0] ctl_word;
   logic        low_byte_seen;
   logic [7:0]  read_ahead;
   logic        irq_flag;
   logic [2:0]  mode_bits;
   logic [5:0]  setting_flags;
   logic [3:0]  name_base;
   logic [7:0]  color_base;
   logic [2:0]  pattern_base;
   logic [6:0]  sprite_attr_base;
   logic [2:0]  sprite_pat_base;
   logic [7:0]  text_colors;

   reply_type    port_reply_q [$];
   stim_row_type dir_rows [DIR_ROWS];
   int           mismatches;
   int           n_items;
   int           n_status, n_reads, n_writes, n_ctl_bytes, n_reg_loads, n_prefetch_loads;
   int           n_irq_status;
   bit           steady;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("vdp_cpu_port_interface_unit: mismatch");
      $finish;
   end

   function automatic int advance_pointer();
      logic [PTR_W-1:0] addr;
      addr = ctl_word[PTR_W-1:0];
      ctl_word[PTR_W-1:0] = addr + 1'b1;
      return int'(addr) % VRAM_SIZE;
   endfunction

   function automatic void load_display_reg(logic [2:0] sel, logic [7:0] d);
      case (vdp_reg_type'(sel))
         REG_MODE0: begin
            setting_flags[0] = d[0];
            mode_bits[2] = d[1];
         end
         REG_MODE1: begin
            setting_flags[5:1] = {d[7], d[6], d[5], d[1], d[0]};
            mode_bits[1:0] = {d[3], d[4]};
         end
         REG_NAME_BASE:    name_base = d[3:0];
         REG_COLOR_BASE:   color_base = d;
         REG_PATTERN_BASE: pattern_base = d[2:0];
         REG_SPRITE_ATTR:  sprite_attr_base = d[6:0];
         REG_SPRITE_PAT:   sprite_pat_base = d[2:0];
         default:          text_colors = d;
      endcase
   endfunction

   function automatic reply_type predict_port_access(access_type a);
      reply_type r;
      int        addr;
      r.read_data = '0;
      if (a.raise_irq) irq_flag = 1'b1;
      case (a.cmd)
         CMD_STATUS_READ: begin
            low_byte_seen = 1'b0;
            r.read_data = {irq_flag, a.overflow, a.collision, a.fifth_idx};
            irq_flag = 1'b0;
         end
         CMD_DATA_READ: begin
            r.read_data = read_ahead;
            low_byte_seen = 1'b0;
            read_ahead = vram_mirror[advance_pointer()];
         end
         CMD_DATA_WRITE: begin
            low_byte_seen = 1'b0;
            addr = advance_pointer();
            vram_mirror[addr] = a.wdata;
            if (!vram_written[addr]) written_addrs.push_back(addr);
            vram_written[addr] = 1'b1;
         end
         default: begin
            if (!low_byte_seen) begin
               ctl_word[7:0] = a.wdata;
               low_byte_seen = 1'b1;
            end else begin
               ctl_word[15:8] = a.wdata;
               low_byte_seen = 1'b0;
               if (ctl_word[15])
                  load_display_reg(ctl_word[10:8], ctl_word[7:0]);
               else if (!ctl_word[14])
                  read_ahead = vram_mirror[advance_pointer()];
            end
         end
      endcase
      r.irq = irq_flag;
      r.ptr = ctl_word[PTR_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type row(vdp_cmd_type c, logic [7:0] d, logic [4:0] fidx,
                                        logic col, logic ovf, logic irq, logic chk,
                                        logic [7:0] rd, logic eirq, logic [PTR_W-1:0] ptr);
      stim_row_type s;
      s.acc = '{c, d, fidx, col, ovf, irq};
      s.chk = chk;
      s.typed = '{rd, eirq, ptr};
      return s;
   endfunction

   function automatic stim_row_type mk(vdp_cmd_type c, logic [7:0] d);
      return row(c, d, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0), 1'b0, '0, 1'b0, '0);
   endfunction

   // call at a falling edge; returns at the falling edge after the transaction is taken
   task automatic send(input stim_row_type s_in);
      stim_row_type s;
      reply_type    r;
      logic [15:0]  word;
      int           gap;
      s = s_in;
      // keep away from memory that was never written
      if (s.acc.cmd == CMD_DATA_READ
          && !vram_written[int'(ctl_word[PTR_W-1:0]) % VRAM_SIZE])
         s.acc.cmd = CMD_DATA_WRITE;
      if (s.acc.cmd == CMD_CONTROL && low_byte_seen) begin
         word = {s.acc.wdata, ctl_word[7:0]};
         if (!word[15] && !word[14] && !vram_written[int'(word[PTR_W-1:0]) % VRAM_SIZE])
            s.acc.wdata[6] = 1'b1;
      end
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd <= s.acc.cmd;
      req_wdata <= s.acc.wdata;
      req_fifth_sprite_index <= s.acc.fifth_idx;
      req_sprite_collision_flag <= s.acc.collision;
      req_sprite_overflow_flag <= s.acc.overflow;
      req_raise_irq <= s.acc.raise_irq;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (s.acc.cmd)
         CMD_STATUS_READ: n_status++;
         CMD_DATA_READ:   n_reads++;
         CMD_DATA_WRITE:  n_writes++;
         default: begin
            n_ctl_bytes++;
            if (low_byte_seen && s.acc.wdata[7]) n_reg_loads++;
            if (low_byte_seen && !s.acc.wdata[7] && !s.acc.wdata[6]) n_prefetch_loads++;
         end
      endcase
      r = predict_port_access(s.acc);
      if (s.acc.cmd == CMD_STATUS_READ && r.read_data[7]) n_irq_status++;
      port_reply_q.push_back(s.chk ? s.typed : r);
      n_items++;
      @(negedge clock);
   endtask

   task automatic reset_latch();
      if (low_byte_seen) send(mk(CMD_STATUS_READ, 8'($urandom_range(0, 255))));
   endtask

   task automatic load_address();
      logic [PTR_W-1:0] target;
      logic             prefetch;
      reset_latch();
      prefetch = (written_addrs.size() > 0) && ($urandom_range(0, 1) == 1);
      if (prefetch)
         target = PTR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      else
         case ($urandom_range(0, 3))
            0, 1:    target = PTR_W'($urandom_range(0, 63));
            2:       target = PTR_W'($urandom_range(16320, 16383));
            default: target = PTR_W'($urandom_range(0, 16383));
         endcase
      send(mk(CMD_CONTROL, target[7:0]));
      send(mk(CMD_CONTROL, {1'b0, !prefetch, target[13:8]}));
   endtask

   task automatic load_register_pair();
      reset_latch();
      send(mk(CMD_CONTROL, 8'($urandom_range(0, 255))));
      send(mk(CMD_CONTROL, {1'b1, 7'($urandom_range(0, 127))}));
   endtask

   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_valid) begin
         if (port_reply_q.size() == 0) begin
            $error("unexpected reply: read_data %0h irq_out %0b vram_pointer %0h",
                   rsp_read_data, rsp_irq_out, rsp_vram_pointer);
            mismatches++;
         end else begin
            e = port_reply_q.pop_front();
            if (rsp_read_data !== e.read_data) begin
               $error("read_data: expected %0h, got %0h", e.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_irq_out !== e.irq) begin
               $error("irq_out: expected %0b, got %0b", e.irq, rsp_irq_out);
               mismatches++;
            end
            if (rsp_vram_pointer !== e.ptr) begin
               $error("vram_pointer: expected %0h, got %0h", e.ptr, rsp_vram_pointer);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int pick;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_STATUS_READ;
      req_wdata = '0;
      req_fifth_sprite_index = '0;
      req_sprite_collision_flag = 1'b0;
      req_sprite_overflow_flag = 1'b0;
      req_raise_irq = 1'b0;
      ctl_word = '0;
      low_byte_seen = 1'b0;
      read_ahead = '0;
      irq_flag = 1'b0;
      mode_bits = '0;
      setting_flags = '0;
      name_base = '0;
      color_base = '0;
      pattern_base = '0;
      sprite_attr_base = '0;
      sprite_pat_base = '0;
      text_colors = '0;
      mismatches = 0;
      n_items = 0;
      n_status = 0;
      n_reads = 0;
      n_writes = 0;
      n_ctl_bytes = 0;
      n_reg_loads = 0;
      n_prefetch_loads = 0;
      n_irq_status = 0;
      steady = 1'b0;

      dir_rows[0]  = row(CMD_STATUS_READ, 8'h00, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0000);
      dir_rows[1]  = row(CMD_STATUS_READ, 8'hFF, 5'd31, 1, 1, 1, 1, 8'hFF, 0, 14'h0000);
      dir_rows[2]  = row(CMD_DATA_WRITE,  8'hAA, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0001);
      dir_rows[3]  = row(CMD_DATA_WRITE,  8'h55, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0002);
      dir_rows[4]  = row(CMD_CONTROL,     8'hFF, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[5]  = row(CMD_CONTROL,     8'h7F, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h3FFF);
      dir_rows[6]  = row(CMD_DATA_WRITE,  8'h11, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0000);
      dir_rows[7]  = row(CMD_CONTROL,     8'h00, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[8]  = row(CMD_CONTROL,     8'h00, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0001);
      dir_rows[9]  = row(CMD_DATA_READ,   8'h00, 5'd0,  0, 0, 0, 1, 8'hAA, 0, 14'h0002);
      dir_rows[10] = row(CMD_CONTROL,     8'hFF, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[11] = row(CMD_CONTROL,     8'h3F, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0000);
      dir_rows[12] = row(CMD_DATA_READ,   8'h00, 5'd0,  0, 0, 0, 1, 8'h11, 0, 14'h0001);
      dir_rows[13] = row(CMD_CONTROL,     8'hFF, 5'd0,  0, 0, 1, 0, 8'h00, 0, 14'h0000);
      dir_rows[14] = row(CMD_CONTROL,     8'h81, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[15] = row(CMD_CONTROL,     8'h00, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[16] = row(CMD_DATA_WRITE,  8'h77, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[17] = row(CMD_CONTROL,     8'h00, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[18] = row(CMD_CONTROL,     8'h41, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[19] = row(CMD_STATUS_READ, 8'h00, 5'd10, 0, 1, 0, 1, 8'hCA, 0, 14'h0100);
      dir_rows[20] = row(CMD_CONTROL,     8'h00, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[21] = row(CMD_STATUS_READ, 8'h00, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[22] = row(CMD_CONTROL,     8'h07, 5'd0,  0, 0, 0, 0, 8'h00, 0, 14'h0000);
      dir_rows[23] = row(CMD_CONTROL,     8'h87, 5'd0,  0, 0, 0, 1, 8'h00, 0, 14'h0707);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) send(dir_rows[i]);

      while (n_items < DIR_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) steady = !steady;
         pick = $urandom_range(0, 99);
         if (pick < 12)
            send(mk(CMD_STATUS_READ, 8'($urandom_range(0, 255))));
         else if (pick < 30)
            repeat ($urandom_range(1, 6)) send(mk(CMD_DATA_WRITE, 8'($urandom_range(0, 255))));
         else if (pick < 45)
            repeat ($urandom_range(1, 4)) send(mk(CMD_DATA_READ, 8'($urandom_range(0, 255))));
         else if (pick < 62)
            load_address();
         else if (pick < 80)
            load_register_pair();
         else if (pick < 90) begin
            // break a pair with another access
            send(mk(CMD_CONTROL, 8'($urandom_range(0, 255))));
            send(mk(vdp_cmd_type'($urandom_range(0, 2)), 8'($urandom_range(0, 255))));
            if ($urandom_range(0, 1) == 1) send(mk(CMD_CONTROL, 8'($urandom_range(0, 255))));
         end else
            send(mk(vdp_cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      end
      start <= 1'b0;

      while (port_reply_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d transactions: %0d status reads, %0d data reads, %0d data writes",
               n_items, n_status, n_reads, n_writes);
      $display("%0d control bytes, %0d register loads, %0d read-ahead address loads, %0d irq",
               n_ctl_bytes, n_reg_loads, n_prefetch_loads, n_irq_status);
      if (mismatches == 0)
         $display("vdp_cpu_port_interface_unit: match");
      else
         $display("vdp_cpu_port_interface_unit: mismatch");
      $finish;
   end

endmodule
